@@ design/bps_pkg.sv @@
// shared types, codes and constants of the ballistic projectile stepper
package bps_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // operation codes of an input transaction
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_MOVE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_GROUND = 2'd2;
  localparam logic [1:0] ST_SPEED  = 2'd3;

  // configuration register indexes
  localparam logic CFG_START_SPEED = 1'b0;
  localparam logic CFG_MOVE_STEP   = 1'b1;

  // iteration counts of the shared unit
  localparam int CNT_W      = 6;
  localparam int MUL_STEPS  = 40;
  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 32;

  typedef enum logic [2:0] {
    UOP_MUL  = 3'b001,
    UOP_DIV  = 3'b010,
    UOP_SQRT = 3'b100
  } uop_t;

  typedef struct packed {
    logic        start;
    uop_t        op;
    logic [63:0] arg_a;
    logic [39:0] arg_b;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [79:0] result;
  } unit_rsp_t;

endpackage

@@ design/bps_iter_unit.sv @@
// shared radix-2 unit: shift-add multiply, restoring divide, digit square root
module bps_iter_unit import bps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  uop_t             op_r, op_nxt;
  logic [39:0]      opa_r, opa_nxt;
  logic [40:0]      acc_r, acc_nxt;
  logic [63:0]      sh_r, sh_nxt;
  logic [31:0]      root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;

  logic [40:0] add_x, add_y;
  logic        add_sub;
  logic [41:0] sum;
  logic        ge;
  logic [32:0] div_t;
  logic [34:0] sq_r4;

  // one shared adder / subtractor
  always_comb begin
    div_t   = {acc_r[31:0], sh_r[63]};
    sq_r4   = {acc_r[32:0], sh_r[63:62]};
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (op_r)
      UOP_MUL: begin
        add_x = {1'b0, acc_r[39:0]};
        add_y = sh_r[0] ? {1'b0, opa_r} : '0;
      end
      UOP_DIV: begin
        add_x   = {8'b0, div_t};
        add_y   = {9'b0, opa_r[31:0]};
        add_sub = 1'b1;
      end
      UOP_SQRT: begin
        add_x   = {6'b0, sq_r4};
        add_y   = {7'b0, root_r, 2'b01};
        add_sub = 1'b1;
      end
      default: begin
        add_x = '0;
      end
    endcase
    sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + 42'(add_sub);
    ge  = sum[41];
  end

  always_comb begin
    op_nxt   = op_r;
    opa_nxt  = opa_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = run_r && (cnt_r == '0);
    if (req_i.start) begin
      op_nxt   = req_i.op;
      run_nxt  = 1'b1;
      root_nxt = '0;
      case (req_i.op)
        UOP_MUL: begin
          opa_nxt = req_i.arg_a[39:0];
          acc_nxt = '0;
          sh_nxt  = {24'b0, req_i.arg_b};
          cnt_nxt = CNT_W'(MUL_STEPS - 1);
        end
        UOP_DIV: begin
          opa_nxt = {8'b0, req_i.arg_b[31:0]};
          acc_nxt = {9'b0, req_i.arg_a[63:32]};
          sh_nxt  = {req_i.arg_a[31:0], 32'b0};
          cnt_nxt = CNT_W'(DIV_STEPS - 1);
        end
        default: begin
          opa_nxt = '0;
          acc_nxt = '0;
          sh_nxt  = req_i.arg_a;
          cnt_nxt = CNT_W'(SQRT_STEPS - 1);
        end
      endcase
    end else if (run_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
      end
      case (op_r)
        UOP_MUL: begin
          acc_nxt = {1'b0, sum[40:1]};
          sh_nxt  = {24'b0, sum[0], sh_r[39:1]};
        end
        UOP_DIV: begin
          acc_nxt = ge ? {8'b0, sum[32:0]} : {8'b0, div_t};
          sh_nxt  = {sh_r[62:0], ge};
        end
        UOP_SQRT: begin
          acc_nxt  = ge ? {6'b0, sum[34:0]} : {6'b0, sq_r4};
          root_nxt = {root_r[30:0], ge};
          sh_nxt   = {sh_r[61:0], 2'b00};
        end
        default: begin
          run_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      op_r   <= UOP_MUL;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
    end
    opa_r  <= opa_nxt;
    acc_r  <= acc_nxt;
    sh_r   <= sh_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  always_comb begin
    rsp_o.done = done_r;
    case (op_r)
      UOP_MUL:  rsp_o.result = {acc_r[39:0], sh_r[39:0]};
      UOP_DIV:  rsp_o.result = {48'b0, sh_r[31:0]};
      default:  rsp_o.result = {48'b0, root_r};
    endcase
  end

endmodule

@@ design/ballistic_projectile_stepper.sv @@
// top level: projectile state, sequencer and result register around the shared unit
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_stall    | operation, times, from_self, start, aim
//  out_    | output    | out_valid / out_stall  | status, position, velocity, schedule
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  one transaction at a time; the shared unit sets the latency: a move runs
//  four multiplies on it, a start runs three multiplies, a square root and
//  three multiply and divide pairs after the normalizing shift; a query, or a
//  reject in decode, goes straight to the emit state
//  rst_n is synchronous: state and handshakes clear, config resets (move step 1.0)
//  a stalled result holds; a finished transaction waits in the emit state
module ballistic_projectile_stepper import bps_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [39:0]        in_event_time,
  input  logic [39:0]        in_previous_time,
  input  logic               in_from_self,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_start_z,
  input  logic signed [31:0] in_aim_x,
  input  logic signed [31:0] in_aim_y,
  input  logic signed [31:0] in_aim_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic [39:0]        out_next_move_time,
  output logic [30:0]        out_speed_reply,
  output logic [15:0]        out_steps_taken,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [39:0]        cfg_data
);

  // gravity 9.8 and the 0.1 time floor, both rounded, and the 1.0 default step
  localparam logic [39:0] GRAV_Q   = 40'(((64'd98 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [39:0] MIN_TIME = 40'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [39:0] STEP_RST = 40'(64'd1 << FRAC_BITS);
  localparam logic [79:0] HALF_P   = 80'(1) << (FRAC_BITS - 1);
  localparam logic [79:0] ONE_P    = 80'(1) << FRAC_BITS;
  localparam int          BIG_SH   = 33 + FRAC_BITS;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECODE = 11'b00000000010,
    S_NORM   = 11'b00000000100,
    S_SQ     = 11'b00000001000,
    S_SQRT   = 11'b00000010000,
    S_SPMUL  = 11'b00000100000,
    S_DIV    = 11'b00001000000,
    S_GMUL   = 11'b00010000000,
    S_VMUL   = 11'b00100000000,
    S_FINISH = 11'b01000000000,
    S_EMIT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;

  // latched transaction
  logic [1:0]  op_r, op_nxt;
  logic [39:0] t_r, t_nxt;
  logic [39:0] prev_r, prev_nxt;
  logic        self_r, self_nxt;
  logic signed [31:0] spos_r [3];
  logic signed [31:0] spos_nxt [3];
  logic [31:0] mag_r [3];
  logic [31:0] mag_nxt [3];
  logic [2:0]  sgn_r, sgn_nxt;

  // working values
  logic [63:0] len2_r, len2_nxt;
  logic [31:0] len_r, len_nxt;
  logic [63:0] num_r, num_nxt;
  logic [39:0] delta_r, delta_nxt;
  logic signed [31:0] nv1_r, nv1_nxt;
  logic [33:0] wmag_r, wmag_nxt;
  logic        wsgn_r, wsgn_nxt;
  logic signed [31:0] np_r [3];
  logic signed [31:0] np_nxt [3];

  // object state
  logic signed [31:0] pos_r [3];
  logic signed [31:0] pos_nxt [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] vel_nxt [3];
  logic [39:0] last_t_r, last_t_nxt;
  logic        flight_r, flight_nxt;
  logic [15:0] steps_r, steps_nxt;

  // pending result
  logic [1:0]  res_status_r, res_status_nxt;
  logic [39:0] res_next_r, res_next_nxt;
  logic [30:0] res_spd_r, res_spd_nxt;
  logic        res_zero_r, res_zero_nxt;
  logic        res_clear_r, res_clear_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic signed [31:0] out_pos_r [3];
  logic signed [31:0] out_pos_nxt [3];
  logic signed [31:0] out_vel_r [3];
  logic signed [31:0] out_vel_nxt [3];
  logic [39:0] out_next_r, out_next_nxt;
  logic [30:0] out_spd_r, out_spd_nxt;
  logic [15:0] out_steps_r, out_steps_nxt;

  // configuration
  logic [30:0] start_speed_r;
  logic [39:0] move_step_r;

  unit_req_t req;
  unit_rsp_t rsp;

  logic        rej;
  logic        start_bad, move_bad, prod_big;
  logic [79:0] gd_full, gh_full, r_full;
  logic signed [35:0] v1_ext, nv1_w, w_w, pos_ext, r_ext, np_w;
  logic [35:0] w_abs;
  logic        vneg;
  logic [33:0] vmag;
  logic [40:0] sched;
  logic [31:0] qv;

  bps_iter_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  always_comb begin
    start_bad = flight_r || (t_r < MIN_TIME) ||
                ((mag_r[0] | mag_r[1] | mag_r[2]) == '0) ||
                (start_speed_r == '0) || (move_step_r == '0);
    move_bad  = !flight_r || (t_r < MIN_TIME) || (prev_r < MIN_TIME) ||
                (t_r < prev_r) || (prev_r != last_t_r) || !self_r;

    // rounding and range checks on the unit's product
    prod_big = (rsp.result >> BIG_SH) != '0;
    gd_full  = (rsp.result + HALF_P) >> FRAC_BITS;
    gh_full  = (rsp.result + ONE_P) >> (FRAC_BITS + 1);
    r_full   = gd_full;
    v1_ext   = 36'(vel_r[1]);
    nv1_w    = v1_ext - $signed({2'b0, gd_full[33:0]});
    w_w      = v1_ext - $signed({2'b0, gh_full[33:0]});
    w_abs    = w_w[35] ? 36'(-w_w) : 36'(w_w);

    // velocity term of the current axis in the position update
    case (idx_r)
      2'd0: begin
        vneg = vel_r[0][31];
        vmag = {2'b00, (vel_r[0][31] ? 32'(-vel_r[0]) : 32'(vel_r[0]))};
      end
      2'd1: begin
        vneg = wsgn_r;
        vmag = wmag_r;
      end
      default: begin
        vneg = vel_r[2][31];
        vmag = {2'b00, (vel_r[2][31] ? 32'(-vel_r[2]) : 32'(vel_r[2]))};
      end
    endcase
    pos_ext = 36'(pos_r[idx_r]);
    r_ext   = $signed({2'b0, r_full[33:0]});
    np_w    = vneg ? pos_ext - r_ext : pos_ext + r_ext;

    sched = {1'b0, t_r} + {1'b0, move_step_r};
    qv    = rsp.result[31:0];
  end

  always_comb begin
    state_nxt      = state_r;
    busy_nxt       = busy_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    t_nxt          = t_r;
    prev_nxt       = prev_r;
    self_nxt       = self_r;
    spos_nxt       = spos_r;
    mag_nxt        = mag_r;
    sgn_nxt        = sgn_r;
    len2_nxt       = len2_r;
    len_nxt        = len_r;
    num_nxt        = num_r;
    delta_nxt      = delta_r;
    nv1_nxt        = nv1_r;
    wmag_nxt       = wmag_r;
    wsgn_nxt       = wsgn_r;
    np_nxt         = np_r;
    pos_nxt        = pos_r;
    vel_nxt        = vel_r;
    last_t_nxt     = last_t_r;
    flight_nxt     = flight_r;
    steps_nxt      = steps_r;
    res_status_nxt = res_status_r;
    res_next_nxt   = res_next_r;
    res_spd_nxt    = res_spd_r;
    res_zero_nxt   = res_zero_r;
    res_clear_nxt  = res_clear_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_vel_nxt    = out_vel_r;
    out_next_nxt   = out_next_r;
    out_spd_nxt    = out_spd_r;
    out_steps_nxt  = out_steps_r;
    rej            = 1'b0;
    req.start      = 1'b0;
    req.op         = UOP_MUL;
    req.arg_a      = '0;
    req.arg_b      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_operation;
          t_nxt       = in_event_time;
          prev_nxt    = in_previous_time;
          self_nxt    = in_from_self;
          spos_nxt[0] = in_start_x;
          spos_nxt[1] = in_start_y;
          spos_nxt[2] = in_start_z;
          mag_nxt[0]  = in_aim_x[31] ? 32'(-in_aim_x) : 32'(in_aim_x);
          mag_nxt[1]  = in_aim_y[31] ? 32'(-in_aim_y) : 32'(in_aim_y);
          mag_nxt[2]  = in_aim_z[31] ? 32'(-in_aim_z) : 32'(in_aim_z);
          sgn_nxt     = {in_aim_z[31], in_aim_y[31], in_aim_x[31]};
          res_status_nxt = ST_REJECT;
          res_next_nxt   = '0;
          res_spd_nxt    = '0;
          res_zero_nxt   = 1'b0;
          res_clear_nxt  = 1'b0;
          state_nxt      = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_r)
          OP_START: begin
            if (start_bad) begin
              rej = 1'b1;
            end else begin
              state_nxt = S_NORM;
            end
          end
          OP_MOVE: begin
            if (move_bad) begin
              rej = 1'b1;
            end else begin
              delta_nxt = t_r - prev_r;
              state_nxt = S_GMUL;
            end
          end
          OP_QUERY: begin
            if (flight_r) begin
              res_status_nxt = ST_SPEED;
              res_spd_nxt    = start_speed_r;
              state_nxt      = S_EMIT;
            end else begin
              rej = 1'b1;
            end
          end
          default: begin
            rej = 1'b1;
          end
        endcase
      end
      S_NORM: begin
        // scale the aim up until its largest magnitude reaches 2^30
        if (((mag_r[0] | mag_r[1] | mag_r[2]) & 32'hC000_0000) == '0) begin
          mag_nxt[0] = {mag_r[0][30:0], 1'b0};
          mag_nxt[1] = {mag_r[1][30:0], 1'b0};
          mag_nxt[2] = {mag_r[2][30:0], 1'b0};
        end else begin
          idx_nxt   = 2'd0;
          len2_nxt  = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        req.op    = UOP_MUL;
        req.arg_a = 64'(mag_r[idx_r]);
        req.arg_b = 40'(mag_r[idx_r]);
        if (!busy_r) begin
          req.start = 1'b1;
          busy_nxt  = 1'b1;
        end else if (rsp.done) begin
          busy_nxt = 1'b0;
          len2_nxt = len2_r + rsp.result[63:0];
          if (idx_r == 2'd2) begin
            state_nxt = S_SQRT;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      S_SQRT: begin
        req.op    = UOP_SQRT;
        req.arg_a = len2_r;
        if (!busy_r) begin
          req.start = 1'b1;
          busy_nxt  = 1'b1;
        end else if (rsp.done) begin
          busy_nxt  = 1'b0;
          len_nxt   = rsp.result[31:0];
          idx_nxt   = 2'd0;
          state_nxt = S_SPMUL;
        end
      end
      S_SPMUL: begin
        req.op    = UOP_MUL;
        req.arg_a = 64'(mag_r[idx_r]);
        req.arg_b = 40'(start_speed_r);
        if (!busy_r) begin
          req.start = 1'b1;
          busy_nxt  = 1'b1;
        end else if (rsp.done) begin
          busy_nxt  = 1'b0;
          num_nxt   = rsp.result[63:0] + 64'(len_r[31:1]);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        req.op    = UOP_DIV;
        req.arg_a = num_r;
        req.arg_b = 40'(len_r);
        if (!busy_r) begin
          req.start = 1'b1;
          busy_nxt  = 1'b1;
        end else if (rsp.done) begin
          busy_nxt       = 1'b0;
          vel_nxt[idx_r] = sgn_r[idx_r] ? $signed(-qv) : $signed(qv);
          if (idx_r == 2'd2) begin
            pos_nxt    = spos_r;
            flight_nxt = 1'b1;
            steps_nxt  = '0;
            last_t_nxt = t_r;
            state_nxt  = S_FINISH;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_SPMUL;
          end
        end
      end
      S_GMUL: begin
        req.op    = UOP_MUL;
        req.arg_a = 64'(GRAV_Q);
        req.arg_b = delta_r;
        if (!busy_r) begin
          req.start = 1'b1;
          busy_nxt  = 1'b1;
        end else if (rsp.done) begin
          busy_nxt = 1'b0;
          // the new vertical velocity must stay in range
          if (prod_big || !((nv1_w[35:31] == 5'b00000) || (nv1_w[35:31] == 5'b11111))) begin
            rej = 1'b1;
          end else begin
            nv1_nxt   = nv1_w[31:0];
            wmag_nxt  = w_abs[33:0];
            wsgn_nxt  = w_w[35];
            idx_nxt   = 2'd0;
            state_nxt = S_VMUL;
          end
        end
      end
      S_VMUL: begin
        req.op    = UOP_MUL;
        req.arg_a = 64'(vmag);
        req.arg_b = delta_r;
        if (!busy_r) begin
          req.start = 1'b1;
          busy_nxt  = 1'b1;
        end else if (rsp.done) begin
          busy_nxt = 1'b0;
          if (prod_big || !((np_w[35:31] == 5'b00000) || (np_w[35:31] == 5'b11111))) begin
            rej = 1'b1;
          end else begin
            np_nxt[idx_r] = np_w[31:0];
            if (idx_r == 2'd2) begin
              pos_nxt[0] = np_r[0];
              pos_nxt[1] = np_r[1];
              pos_nxt[2] = np_w[31:0];
              vel_nxt[1] = nv1_r;
              last_t_nxt = t_r;
              if (steps_r != 16'hFFFF) begin
                steps_nxt = steps_r + 16'd1;
              end
              state_nxt = S_FINISH;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
        end
      end
      S_FINISH: begin
        if (pos_r[1] <= 32'sd0) begin
          // reached the ground: report, then drop the object
          res_status_nxt = ST_GROUND;
          res_clear_nxt  = 1'b1;
        end else if (sched[40]) begin
          // schedule overflow: drop the object and report the cleared state
          res_status_nxt = ST_REJECT;
          res_zero_nxt   = 1'b1;
          res_clear_nxt  = 1'b1;
        end else begin
          res_status_nxt = ST_OK;
          res_next_nxt   = sched[39:0];
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_next_nxt   = res_next_r;
          out_spd_nxt    = res_spd_r;
          out_steps_nxt  = res_zero_r ? 16'd0 : steps_r;
          for (int i = 0; i < 3; i++) begin
            out_pos_nxt[i] = res_zero_r ? 32'sd0 : pos_r[i];
            out_vel_nxt[i] = res_zero_r ? 32'sd0 : vel_r[i];
          end
          if (res_clear_r) begin
            for (int i = 0; i < 3; i++) begin
              pos_nxt[i] = 32'sd0;
              vel_nxt[i] = 32'sd0;
            end
            last_t_nxt = '0;
            flight_nxt = 1'b0;
            steps_nxt  = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // any rejection reports the untouched state
    if (rej) begin
      res_status_nxt = ST_REJECT;
      res_next_nxt   = '0;
      res_spd_nxt    = '0;
      state_nxt      = S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      flight_r      <= 1'b0;
      steps_r       <= '0;
      last_t_r      <= '0;
      start_speed_r <= '0;
      move_step_r   <= STEP_RST;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= 32'sd0;
        vel_r[i] <= 32'sd0;
      end
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      flight_r    <= flight_nxt;
      steps_r     <= steps_nxt;
      last_t_r    <= last_t_nxt;
      pos_r       <= pos_nxt;
      vel_r       <= vel_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_START_SPEED: start_speed_r <= cfg_data[30:0];
          CFG_MOVE_STEP:   move_step_r   <= cfg_data;
          default:         move_step_r   <= move_step_r;
        endcase
      end
    end
    idx_r          <= idx_nxt;
    op_r           <= op_nxt;
    t_r            <= t_nxt;
    prev_r         <= prev_nxt;
    self_r         <= self_nxt;
    spos_r         <= spos_nxt;
    mag_r          <= mag_nxt;
    sgn_r          <= sgn_nxt;
    len2_r         <= len2_nxt;
    len_r          <= len_nxt;
    num_r          <= num_nxt;
    delta_r        <= delta_nxt;
    nv1_r          <= nv1_nxt;
    wmag_r         <= wmag_nxt;
    wsgn_r         <= wsgn_nxt;
    np_r           <= np_nxt;
    res_status_r   <= res_status_nxt;
    res_next_r     <= res_next_nxt;
    res_spd_r      <= res_spd_nxt;
    res_zero_r     <= res_zero_nxt;
    res_clear_r    <= res_clear_nxt;
    out_status_r   <= out_status_nxt;
    out_pos_r      <= out_pos_nxt;
    out_vel_r      <= out_vel_nxt;
    out_next_r     <= out_next_nxt;
    out_spd_r      <= out_spd_nxt;
    out_steps_r    <= out_steps_nxt;
  end

  // ports
  assign in_stall           = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_pos_x          = out_pos_r[0];
  assign out_pos_y          = out_pos_r[1];
  assign out_pos_z          = out_pos_r[2];
  assign out_vel_x          = out_vel_r[0];
  assign out_vel_y          = out_vel_r[1];
  assign out_vel_z          = out_vel_r[2];
  assign out_next_move_time = out_next_r;
  assign out_speed_reply    = out_spd_r;
  assign out_steps_taken    = out_steps_r;

endmodule

@@ design/bps_checker.sv @@
// port-level checks of the ballistic projectile stepper, bound to the top level
module bps_checker import bps_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [39:0] out_next_move_time,
  input logic [30:0] out_speed_reply
);

  // a held result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_next_move_time) && $stable(out_speed_reply))
    else $error("stalled result changed");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // only a speed reply carries the speed
  a_speed_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_SPEED) |-> out_speed_reply == '0)
    else $error("speed on non-query result");

  // only an accepted schedule carries a move time
  a_next_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_next_move_time == '0)
    else $error("move time on unscheduled result");

endmodule

bind ballistic_projectile_stepper bps_checker u_bps_checker (.*);
